FILE: rtl/core/hsl_pkg.sv
// Shared types, constants and helpers for the HSL to RGB colour converter.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package hsl_pkg;

  // Fraction format: COLOR_BITS fraction bits, one extra bit so that 1.0 fits.
  localparam int unsigned COLOR_BITS = 16;
  localparam int unsigned FRAC_W     = COLOR_BITS + 1;

  typedef logic [FRAC_W-1:0] frac_t;

  localparam frac_t FRAC_ONE  = {1'b1, {COLOR_BITS{1'b0}}};
  localparam frac_t FRAC_HALF = FRAC_ONE >> 1;

  // Hue in 1/5760 of a turn (1/16 degree).
  localparam int unsigned HUE_W = 13;

  typedef logic [HUE_W-1:0] hue_t;

  localparam hue_t HUE_TURN       = HUE_W'(5760);
  localparam hue_t HUE_SIXTH      = HUE_W'(960);
  localparam hue_t HUE_THIRD      = HUE_W'(1920);
  localparam hue_t HUE_HALF       = HUE_W'(2880);
  localparam hue_t HUE_TWO_THIRDS = HUE_W'(3840);

  // Ramp factor: 0..960, multiplied by (q - p) and divided by 960.
  localparam int unsigned FACT_W = 10;

  typedef logic [FACT_W-1:0] fact_t;

  localparam fact_t FACT_FULL = FACT_W'(960);

  // 960 = 15 * 64: shift out 64, then divide by 15 through a reciprocal.
  localparam int unsigned SIXTH_SH  = 6;
  localparam int unsigned PROD_W    = FRAC_W + FACT_W;
  localparam int unsigned QUO_IN_W  = PROD_W - SIXTH_SH;
  localparam int unsigned RECIP_SH  = QUO_IN_W + 4;
  localparam int unsigned RECIP_W   = RECIP_SH - 3;
  localparam int unsigned MUL_W     = QUO_IN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP15 =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'd14) / 64'd15);

  // Queue sizing, shared by the middle queue and the result queue.
  localparam int unsigned Q_DEPTH = 8;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [Q_PTR_W-1:0] qptr_t;
  typedef logic [Q_CNT_W-1:0] qcnt_t;

  localparam qcnt_t Q_FULL_CNT = Q_CNT_W'(Q_DEPTH);

  // Channel order inside the factor array.
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  // Classified item handed from the front to the back.
  typedef struct packed {
    frac_t           p;
    frac_t           diff;
    fact_t [2:0]     fact;
  } mid_item_t;

  typedef struct packed {
    logic      valid;
    mid_item_t item;
  } mid_head_t;

  typedef struct packed {
    frac_t red;
    frac_t green;
    frac_t blue;
  } rgb_t;

  // Piecewise hue ramp, expressed as the factor applied to (q - p).
  function automatic fact_t hue_fact(hue_t t);
    hue_t fall;
    fall = HUE_TWO_THIRDS - t;
    priority if (t < HUE_SIXTH) begin
      return t[FACT_W-1:0];
    end else if (t < HUE_HALF) begin
      return FACT_FULL;
    end else if (t < HUE_TWO_THIRDS) begin
      return fall[FACT_W-1:0];
    end else begin
      return '0;
    end
  endfunction

endpackage

FILE: rtl/core/hsl_front.sv
// Front pipeline: clamps the fractions, wraps the hue, forms q and p and the
// three ramp factors. Three register stages, never stalls. Uses hsl_pkg.
`timescale 1ns / 1ps

module hsl_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_vld_i,
  input  hsl_pkg::hue_t     hue_i,
  input  hsl_pkg::frac_t    saturation_i,
  input  hsl_pkg::frac_t    lightness_i,
  output logic              out_vld_o,
  output hsl_pkg::mid_item_t out_item_o
);
  import hsl_pkg::*;

  localparam int unsigned PW = 2 * FRAC_W + 1;

  // Stage 1 registers
  logic  v1_q;
  hue_t  h1_q;
  frac_t s1_q, l1_q;

  // Stage 2 registers
  logic        v2_q;
  frac_t       m2_q, s2_q, l2_q;
  logic        lo2_q;
  fact_t [2:0] f2_q;

  // Stage 3 registers
  logic      v3_q;
  mid_item_t item3_q;

  // Stage 1 logic
  frac_t s1_d, l1_d;
  hue_t  h1_d;

  // Stage 2 logic
  hue_t           tr, tb, tr_sum;
  logic           lo;
  logic [FRAC_W:0] mul_b;
  logic [PW-1:0]  prod;
  fact_t [2:0]    f2_d;

  // Stage 3 logic
  logic [FRAC_W:0]   sum_ls, q_hi, q_raw;
  frac_t             q;
  logic [FRAC_W+1:0] p_raw;
  frac_t             p;
  mid_item_t         item3_d;

  always_comb begin
    s1_d = (saturation_i > FRAC_ONE) ? FRAC_ONE : saturation_i;
    l1_d = (lightness_i > FRAC_ONE) ? FRAC_ONE : lightness_i;
    h1_d = (hue_i >= HUE_TURN) ? hue_i - HUE_TURN : hue_i;
  end

  always_comb begin
    tr_sum = h1_q + HUE_THIRD;
    tr     = (tr_sum >= HUE_TURN) ? tr_sum - HUE_TURN : tr_sum;
    tb     = (h1_q >= HUE_THIRD) ? h1_q - HUE_THIRD : h1_q + (HUE_TURN - HUE_THIRD);
    f2_d[CH_RED]   = hue_fact(tr);
    f2_d[CH_GREEN] = hue_fact(h1_q);
    f2_d[CH_BLUE]  = hue_fact(tb);
    lo    = (l1_q < FRAC_HALF);
    mul_b = lo ? ({1'b0, FRAC_ONE} + {1'b0, s1_q}) : {1'b0, s1_q};
    prod  = PW'(l1_q) * PW'(mul_b);
  end

  always_comb begin
    sum_ls = {1'b0, l2_q} + {1'b0, s2_q};
    q_hi   = sum_ls - {1'b0, m2_q};
    q_raw  = lo2_q ? {1'b0, m2_q} : q_hi;
    q      = (q_raw > {1'b0, FRAC_ONE}) ? FRAC_ONE : q_raw[FRAC_W-1:0];
    p_raw  = {1'b0, l2_q, 1'b0} - {2'b00, q};
    // clamp below at zero, above at q (q never exceeds one)
    priority if (p_raw[FRAC_W+1]) begin
      p = '0;
    end else if (p_raw[FRAC_W:0] > {1'b0, q}) begin
      p = q;
    end else begin
      p = p_raw[FRAC_W-1:0];
    end
    item3_d.fact = f2_q;
    if (s2_q == '0) begin
      // grey: ramp collapses onto lightness
      item3_d.p    = l2_q;
      item3_d.diff = '0;
    end else begin
      item3_d.p    = p;
      item3_d.diff = q - p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h1_q    <= h1_d;
    s1_q    <= s1_d;
    l1_q    <= l1_d;
    m2_q    <= prod[COLOR_BITS +: FRAC_W];
    s2_q    <= s1_q;
    l2_q    <= l1_q;
    lo2_q   <= lo;
    f2_q    <= f2_d;
    item3_q <= item3_d;
  end

  assign out_vld_o  = v3_q;
  assign out_item_o = item3_q;

endmodule

FILE: rtl/core/hsl_midq.sv
// Short queue between front and back, with the credit count that drives full.
// Uses hsl_pkg.
`timescale 1ns / 1ps

module hsl_midq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               wr_i,
  input  hsl_pkg::mid_item_t wr_item_i,
  input  logic               rd_i,
  output logic               full_o,
  output hsl_pkg::mid_head_t head_o
);
  import hsl_pkg::*;

  mid_item_t mem_q [Q_DEPTH];
  qptr_t     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  qcnt_t     occ_q, occ_d, res_q, res_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    occ_d = occ_q + Q_CNT_W'(wr_i) - Q_CNT_W'(rd_i);
    // reserve a slot for every item still in the front pipeline
    res_d = res_q + Q_CNT_W'(accept_i) - Q_CNT_W'(rd_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
      res_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      occ_q    <= occ_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  assign full_o       = (res_q == Q_FULL_CNT);
  assign head_o.valid = (occ_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

endmodule

FILE: rtl/core/hsl_back.sv
// Back pipeline: evaluates p + (q - p) * factor / 960 for three channels and
// holds finished items in the result queue. Uses hsl_pkg.
`timescale 1ns / 1ps

module hsl_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hsl_pkg::mid_head_t head_i,
  output logic               rd_o,
  input  logic               pop_i,
  output logic               empty_o,
  output hsl_pkg::rgb_t      rgb_o
);
  import hsl_pkg::*;

  logic                    v1_q, v2_q;
  frac_t                   p1_q, p2_q;
  logic [2:0][PROD_W-1:0]  prod1_q;
  logic [2:0][MUL_W-1:0]   mm2_q;
  logic [2:0][MUL_W-1:0]   mm2_d;
  logic [2:0][FRAC_W:0]    res_sum;
  frac_t [2:0]             res;
  rgb_t                    rgb_d;

  rgb_t  mem_q [Q_DEPTH];
  qptr_t wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  qcnt_t occ_q, occ_d, res_q, res_d;
  logic  pop_ok;

  // take from the middle queue only while a result slot is free to reserve
  assign rd_o   = head_i.valid && (res_q != Q_FULL_CNT);
  assign pop_ok = pop_i && (occ_q != '0);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mm2_d[c] = MUL_W'(prod1_q[c][PROD_W-1:SIXTH_SH]) * MUL_W'(RECIP15);
      res_sum[c] = {1'b0, p2_q} + {1'b0, mm2_q[c][RECIP_SH +: FRAC_W]};
      res[c] = (res_sum[c] > {1'b0, FRAC_ONE}) ? FRAC_ONE : res_sum[c][FRAC_W-1:0];
    end
    rgb_d.red   = res[CH_RED];
    rgb_d.green = res[CH_GREEN];
    rgb_d.blue  = res[CH_BLUE];
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (v2_q) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    occ_d = occ_q + Q_CNT_W'(v2_q) - Q_CNT_W'(pop_ok);
    res_d = res_q + Q_CNT_W'(rd_o) - Q_CNT_W'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
      res_q    <= '0;
    end else begin
      v1_q     <= rd_o;
      v2_q     <= v1_q;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      occ_q    <= occ_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      prod1_q[c] <= PROD_W'(head_i.item.diff) * PROD_W'(head_i.item.fact[c]);
    end
    p1_q  <= head_i.item.p;
    p2_q  <= p1_q;
    mm2_q <= mm2_d;
    if (v2_q) begin
      mem_q[wr_ptr_q] <= rgb_d;
    end
  end

  assign empty_o = (occ_q == '0);
  assign rgb_o   = mem_q[rd_ptr_q];

endmodule

FILE: rtl/core/hsl_to_rgb.sv
// Top level of the HSL to RGB colour converter.
// Instantiates hsl_front, hsl_midq and hsl_back; uses hsl_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel: drive hue_i, saturation_i and lightness_i with push high;
//   the item is taken at a rising edge where push is high and full is low.
//   Result channel: while empty is low, red_o, green_o and blue_o carry the
//   oldest result; it is taken at a rising edge where pop is high.
//   Path: a taken item passes three front stages, the middle queue and two
//   back stages into the result queue before it shows on the ports.
//   Throughput: one item per cycle, sustained, as long as results are popped
//   each cycle; the front and back pipelines are fully pipelined and the
//   multipliers are registered.
//   Stall: when pop stays low, results collect in the 8-entry result queue,
//   the back stops draining the 8-entry middle queue, and full rises once
//   every middle slot is spoken for by a queued or in-flight item. No item
//   is dropped.
//   Reset: rst_ni clears all queue pointers, counts and stage valids; after
//   reset empty is high and full is low.

module hsl_to_rgb (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  hsl_pkg::hue_t  hue_i,
  input  hsl_pkg::frac_t saturation_i,
  input  hsl_pkg::frac_t lightness_i,
  output logic           empty,
  input  logic           pop,
  output hsl_pkg::frac_t red_o,
  output hsl_pkg::frac_t green_o,
  output hsl_pkg::frac_t blue_o
);
  import hsl_pkg::*;

  logic      accept;
  logic      front_vld;
  mid_item_t front_item;
  mid_head_t mid_head;
  logic      mid_rd;
  rgb_t      rgb;

  // an item enters only while the middle queue can still promise it a slot
  assign accept = push && !full;

  hsl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_vld_i     (accept),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .lightness_i  (lightness_i),
    .out_vld_o    (front_vld),
    .out_item_o   (front_item)
  );

  hsl_midq u_midq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .wr_i      (front_vld),
    .wr_item_i (front_item),
    .rd_i      (mid_rd),
    .full_o    (full),
    .head_o    (mid_head)
  );

  hsl_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (mid_head),
    .rd_o    (mid_rd),
    .pop_i   (pop),
    .empty_o (empty),
    .rgb_o   (rgb)
  );

  // split the result onto its channel ports
  assign red_o   = rgb.red;
  assign green_o = rgb.green;
  assign blue_o  = rgb.blue;

endmodule

FILE: rtl/core/hsl_chk.sv
// Port-level checker for the HSL to RGB converter, bound to hsl_to_rgb.
// Uses hsl_pkg.
`timescale 1ns / 1ps

module hsl_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           full,
  input logic           empty,
  input logic           pop,
  input hsl_pkg::frac_t red_o,
  input hsl_pkg::frac_t green_o,
  input hsl_pkg::frac_t blue_o
);
  import hsl_pkg::*;

  // hold everything clear while in reset, once the first reset edge has landed
  a_reset_idle: assert property (@(posedge clk_i)
    (!rst_ni ##1 !rst_ni) |-> (empty && !full))
    else $error("queues not clear during reset");

  // results never exceed one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (red_o <= FRAC_ONE && green_o <= FRAC_ONE && blue_o <= FRAC_ONE))
    else $error("channel above one");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(red_o) && $stable(green_o) && $stable(blue_o)))
    else $error("waiting result changed");

  // nothing comes out of an idle block right after reset
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> empty)
    else $error("result without item");

endmodule

bind hsl_to_rgb hsl_chk u_hsl_chk (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .red_o   (red_o),
  .green_o (green_o),
  .blue_o  (blue_o)
);

FILE: tb/sv/hsl_to_rgb_tb.sv
// Self-checking testbench for the HSL to RGB colour converter (hsl_to_rgb).
// Depends on hsl_pkg for the field types and hue constants; needs only the RTL.
`timescale 1ns / 1ps

// Scoreboard: predicts each colour from the accepted item and checks results in order.
class rgb_scoreboard;
  localparam longint UNIT       = longint'(1) << hsl_pkg::COLOR_BITS;
  localparam longint TURN       = longint'(hsl_pkg::HUE_TURN);
  localparam longint SIXTH      = longint'(hsl_pkg::HUE_SIXTH);
  localparam longint THIRD      = longint'(hsl_pkg::HUE_THIRD);
  localparam longint HALF_TURN  = longint'(hsl_pkg::HUE_HALF);
  localparam longint TWO_THIRDS = longint'(hsl_pkg::HUE_TWO_THIRDS);

  hsl_pkg::rgb_t expected_rgb[$];
  int unsigned   mismatches;
  int unsigned   colours_checked;
  int unsigned   grey_items;
  int unsigned   wrapped_hues;
  int unsigned   clamped_fracs;

  function new();
    mismatches      = 0;
    colours_checked = 0;
    grey_items      = 0;
    wrapped_hues    = 0;
    clamped_fracs   = 0;
  endfunction

  function longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > UNIT) return UNIT;
    return v;
  endfunction

  function longint hue_ramp_level(longint p, longint q, longint t);
    if (t < SIXTH) return p + ((q - p) * t) / SIXTH;
    if (t < HALF_TURN) return q;
    if (t < TWO_THIRDS) return p + ((q - p) * (TWO_THIRDS - t)) / SIXTH;
    return p;
  endfunction

  function hsl_pkg::rgb_t convert_hsl(hsl_pkg::hue_t hue, hsl_pkg::frac_t sat,
                                      hsl_pkg::frac_t light);
    longint        h;
    longint        s;
    longint        l;
    longint        q;
    longint        p;
    longint        t_red;
    longint        t_blue;
    hsl_pkg::rgb_t rgb;
    h = longint'(hue);
    s = clamp_unit(longint'(sat));
    l = clamp_unit(longint'(light));
    // wrap once onto the circle
    if (h >= TURN) h -= TURN;
    if (s == 0) begin
      rgb.red   = hsl_pkg::frac_t'(l);
      rgb.green = hsl_pkg::frac_t'(l);
      rgb.blue  = hsl_pkg::frac_t'(l);
      return rgb;
    end
    if (l < UNIT / 2) q = (l * (UNIT + s)) >> hsl_pkg::COLOR_BITS;
    else q = l + s - ((l * s) >> hsl_pkg::COLOR_BITS);
    q = clamp_unit(q);
    p = clamp_unit(2 * l - q);
    if (p > q) p = q;
    t_red = h + THIRD;
    if (t_red >= TURN) t_red -= TURN;
    t_blue = h - THIRD;
    if (t_blue < 0) t_blue += TURN;
    rgb.red   = hsl_pkg::frac_t'(clamp_unit(hue_ramp_level(p, q, t_red)));
    rgb.green = hsl_pkg::frac_t'(clamp_unit(hue_ramp_level(p, q, h)));
    rgb.blue  = hsl_pkg::frac_t'(clamp_unit(hue_ramp_level(p, q, t_blue)));
    return rgb;
  endfunction

  function void note_item(hsl_pkg::hue_t hue, hsl_pkg::frac_t sat, hsl_pkg::frac_t light);
    if (sat == '0) grey_items++;
    if (hue >= hsl_pkg::HUE_TURN) wrapped_hues++;
    if (sat > hsl_pkg::FRAC_ONE || light > hsl_pkg::FRAC_ONE) clamped_fracs++;
    expected_rgb.push_back(convert_hsl(hue, sat, light));
  endfunction

  function int unsigned pending();
    return expected_rgb.size();
  endfunction

  task report(string msg);
    mismatches++;
    $display("[%0t] mismatch %0d: %s", $realtime, mismatches, msg);
  endtask

  task check_channel(string chan, hsl_pkg::frac_t got, hsl_pkg::frac_t want);
    if (got !== want)
      report($sformatf("colour %0d %s got %0d, expected %0d",
                       colours_checked, chan, got, want));
  endtask

  task check_result(hsl_pkg::frac_t red, hsl_pkg::frac_t green, hsl_pkg::frac_t blue);
    hsl_pkg::rgb_t want;
    if (expected_rgb.size() == 0) begin
      report($sformatf("unexpected colour r=%0d g=%0d b=%0d", red, green, blue));
      return;
    end
    want = expected_rgb.pop_front();
    check_channel("red", red, want.red);
    check_channel("green", green, want.green);
    check_channel("blue", blue, want.blue);
    colours_checked++;
  endtask
endclass

module hsl_to_rgb_tb;
  import hsl_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned CALM_TAIL    = 150;   // last items run without idling
  localparam int unsigned HOLD_CYCLES  = 80;    // long receiver hold-off
  localparam int unsigned HOLD_BURST   = 40;    // items offered back to back meanwhile
  localparam int unsigned DRAIN_CYCLES = 20;    // well beyond the input-to-output latency
  localparam longint     CYCLE_LIMIT  = 200000;

  localparam frac_t FRAC_MAX = '1;               // every fraction bit set, above one
  localparam hue_t  HUE_MAX  = '1;               // every hue bit set, wraps once

  logic  clk_i;
  logic  rst_ni       = 1'b0;
  logic  push         = 1'b0;
  logic  pop          = 1'b0;
  hue_t  hue_i        = '0;
  frac_t saturation_i = '0;
  frac_t lightness_i  = '0;
  logic  full;
  logic  empty;
  frac_t red_o;
  frac_t green_o;
  frac_t blue_o;

  rgb_scoreboard colour_board = new();

  // Shared pacing controls: quiet stretches, calm tail and hold requests.
  bit          quiet_phase  = 1'b0;
  bit          calm_tail    = 1'b0;
  int unsigned holds_asked  = 0;
  int unsigned holds_served = 0;
  int unsigned full_cycles  = 0;
  longint      cycle_count  = 0;

  hsl_to_rgb dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .lightness_i (lightness_i),
    .empty       (empty),
    .pop         (pop),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: end the run as failed if it overruns by far.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d colours still pending",
               cycle_count, colour_board.pending());
      $display("hsl_to_rgb_tb: FAIL");
      $finish;
    end
  end

  // Offer one item and hold it until the block takes it. Values of full read
  // just after the edge are those the edge sampled.
  task automatic offer_colour(hue_t h, frac_t s, frac_t l);
    push         <= 1'b1;
    hue_i        <= h;
    saturation_i <= s;
    lightness_i  <= l;
    do @(posedge clk_i); while (full);
    colour_board.note_item(h, s, l);
  endtask

  // Offer an item, then perhaps drop push for a short burst.
  task automatic feed_colour(hue_t h, frac_t s, frac_t l, bit may_idle);
    offer_colour(h, s, l);
    if (may_idle && !quiet_phase && !calm_tail && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Hue: mostly in range, a share near the ramp breakpoints, some past one turn.
  function automatic hue_t pick_hue();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return hue_t'($urandom_range(int'(HUE_TURN), int'(HUE_MAX)));
    if (roll < 22)
      return hue_t'((int'(HUE_SIXTH) * $urandom_range(1, 6) + $urandom_range(0, 2) - 1)
                    % int'(HUE_TURN));
    return hue_t'($urandom_range(0, int'(HUE_TURN) - 1));
  endfunction

  // Fraction: mostly 0..one, with zero, values around half and one, and values above one.
  function automatic frac_t pick_frac();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 10) return frac_t'($urandom_range(int'(FRAC_ONE) + 1, int'(FRAC_MAX)));
    if (roll < 18) begin
      case ($urandom_range(0, 5))
        0: return frac_t'(1);
        1: return FRAC_HALF - 1'b1;
        2: return FRAC_HALF;
        3: return FRAC_HALF + 1'b1;
        4: return FRAC_ONE - 1'b1;
        default: return FRAC_ONE;
      endcase
    end
    return frac_t'($urandom_range(0, int'(FRAC_ONE)));
  endfunction

  // Receiver: check accepted colours, idle in random bursts, serve long holds.
  initial begin
    int unsigned idle_left;
    idle_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) colour_board.check_result(red_o, green_o, blue_o);
      if (full) full_cycles++;
      if (idle_left > 0) begin
        idle_left--;
      end else if (holds_served < holds_asked) begin
        // hold off for a long stretch so that both queues fill and full rises
        holds_served++;
        idle_left = HOLD_CYCLES;
      end else if (!quiet_phase && !calm_tail && $urandom_range(0, 4) == 0) begin
        idle_left = $urandom_range(1, 6);
      end else begin
        idle_left = 0;
      end
      pop <= (idle_left == 0) && (holds_served >= holds_asked);
    end
  end

  // Sender and run control.
  initial begin
    int unsigned burst_left;
    burst_left = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, grey, clamping, hue wrap and every ramp breakpoint.
    feed_colour('0, '0, '0, 1'b1);
    feed_colour('0, '0, FRAC_ONE, 1'b1);
    feed_colour(hue_t'(1000), '0, FRAC_MAX, 1'b1);           // grey with lightness above one
    feed_colour(HUE_MAX, FRAC_MAX, FRAC_MAX, 1'b1);          // every bit set
    feed_colour(hue_t'(100), FRAC_MAX, frac_t'(30000), 1'b1); // saturation above one
    feed_colour(HUE_TURN - 1'b1, FRAC_ONE, FRAC_HALF, 1'b1);
    feed_colour(HUE_TURN, FRAC_ONE, FRAC_HALF, 1'b1);        // exactly one turn wraps to 0
    feed_colour(HUE_SIXTH - 1'b1, FRAC_ONE, FRAC_HALF, 1'b1);
    feed_colour(HUE_SIXTH, frac_t'(40000), frac_t'(20000), 1'b1);
    feed_colour(HUE_THIRD, frac_t'(40000), frac_t'(50000), 1'b1);
    feed_colour(HUE_HALF - 1'b1, frac_t'(12345), frac_t'(54321), 1'b1);
    feed_colour(HUE_HALF, frac_t'(12345), frac_t'(54321), 1'b1);
    feed_colour(HUE_TWO_THIRDS - 1'b1, FRAC_ONE, frac_t'(10000), 1'b1);
    feed_colour(HUE_TWO_THIRDS, FRAC_ONE, frac_t'(10000), 1'b1); // red lands on one turn
    feed_colour(hue_t'(4800), frac_t'(1), frac_t'(1), 1'b1);
    feed_colour(hue_t'(2000), FRAC_ONE, FRAC_HALF - 1'b1, 1'b1); // just below half
    feed_colour(hue_t'(2000), FRAC_ONE, FRAC_HALF + 1'b1, 1'b1);
    feed_colour(hue_t'(300), FRAC_ONE, FRAC_ONE, 1'b1);
    feed_colour(hue_t'(5000), FRAC_ONE, '0, 1'b1);
    feed_colour(hue_t'(7000), frac_t'(65535), frac_t'(65535), 1'b1);

    // Random colours, with quiet stretches and two long receiver holds.
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      quiet_phase = ((i / 50) % 4) == 3;
      calm_tail   = i >= RANDOM_ITEMS - CALM_TAIL;
      if (i == 300 || i == 650) begin
        holds_asked <= holds_asked + 1;
        burst_left = HOLD_BURST;
      end
      feed_colour(pick_hue(), pick_frac(), pick_frac(), burst_left == 0);
      if (burst_left > 0) burst_left--;
    end
    push <= 1'b0;

    // Drain: wait for every expected colour, then for a further drain margin.
    while (colour_board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d colours checked, %0d grey, %0d wrapped hues, %0d clamped fractions",
             colour_board.colours_checked, colour_board.grey_items,
             colour_board.wrapped_hues, colour_board.clamped_fracs);
    $display("summary: input stalled by full for %0d cycles, %0d mismatches",
             full_cycles, colour_board.mismatches);
    if (colour_board.mismatches == 0) begin
      $display("hsl_to_rgb_tb: PASS");
    end else begin
      $display("hsl_to_rgb_tb: FAIL");
    end
    $finish;
  end

endmodule
